// File: design/dspg_pkg.sv
// Shared types and constants for the dual stepper pulse generator.
package dspg_pkg;

  // Bus operation codes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  // Register addresses
  localparam logic [2:0] REG_CTRL   = 3'd0;
  localparam logic [2:0] REG_STEPS  = 3'd1;
  localparam logic [2:0] REG_PERIOD = 3'd2;
  localparam logic [2:0] REG_WIDTH  = 3'd3;

  // Control register bit positions
  localparam int unsigned CTRL_EN  = 0;
  localparam int unsigned CTRL_CLR = 1;

  // Reset values of the timing registers
  localparam logic [31:0] RESET_PERIOD = 32'h0000_1000;
  localparam logic [31:0] RESET_WIDTH  = 32'h0000_0010;

  // Input word
  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  reg_addr;
    logic [31:0] write_data;
  } in_item_t;

  // Result word
  typedef struct packed {
    logic [31:0] read_data;
    logic        step_pin_left;
    logic        dir_pin_left;
    logic        step_pin_right;
    logic        dir_pin_right;
    logic        driver_enable;
    logic        all_done;
  } out_item_t;

endpackage

// File: design/dspg_if.sv
// Valid/ready channel interfaces for the input and result words.
interface dspg_in_if;
  logic              valid;
  logic              ready;
  dspg_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dspg_out_if;
  logic               valid;
  logic               ready;
  dspg_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/dual_stepper_pulse_generator_core.sv
// Two-channel stepper step-pulse generator with a register-bus word interface.
// The result word for an input word is registered in the output register, or in the skid register.
// Throughput: one word per cycle while the skid register is empty; state update and result are one register stage.
// A one-word skid register lets the input side accept one more word while the output stalls.
// Reset (rst_n low, synchronous): control, counts, directions and phases clear;
// periods load 0x1000 and pulse widths 0x10; both output registers empty.
module dual_stepper_pulse_generator_core #(
  parameter int unsigned COUNT_BITS = 15,
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  dspg_in_if.sink           in_ch,
  dspg_out_if.source        out_ch
);

  localparam int unsigned C = COUNT_BITS;
  localparam int unsigned T = TIMER_BITS;

  // Architectural state
  logic [1:0]   ctrl_r, ctrl_nxt;
  logic [1:0]   dir_r, dir_nxt;
  logic [C-1:0] count_r [2];
  logic [C-1:0] count_nxt [2];
  logic [T-1:0] per_r [2];
  logic [T-1:0] per_nxt [2];
  logic [T-1:0] wid_r [2];
  logic [T-1:0] wid_nxt [2];
  logic [T-1:0] ph_r [2];
  logic [T-1:0] ph_nxt [2];

  // Output and skid registers
  logic                out_valid_r, out_valid_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  dspg_pkg::out_item_t out_data_r, out_data_nxt;
  dspg_pkg::out_item_t skid_data_r, skid_data_nxt;

  logic                accept;
  logic                out_take;
  dspg_pkg::out_item_t result;
  logic [63:0]         wd64;
  logic [63:0]         rd64;
  logic [T:0]          per_eff [2];
  logic [T:0]          ph_inc [2];

  assign in_ch.ready = !skid_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_take    = out_valid_r && out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign wd64 = {32'd0, in_ch.data.write_data};

  // Compute next state and read data for the incoming word
  always_comb begin
    ctrl_nxt = ctrl_r;
    dir_nxt  = dir_r;
    rd64     = 64'd0;
    for (int ch = 0; ch < 2; ch++) begin
      count_nxt[ch] = count_r[ch];
      per_nxt[ch]   = per_r[ch];
      wid_nxt[ch]   = wid_r[ch];
      ph_nxt[ch]    = ph_r[ch];
      per_eff[ch]   = (per_r[ch] == '0) ? (T+1)'(1) : {1'b0, per_r[ch]};
      ph_inc[ch]    = {1'b0, ph_r[ch]} + (T+1)'(1);
    end
    if (accept) begin
      case (in_ch.data.opcode)
        dspg_pkg::OP_TICK: begin
          if (ctrl_r[dspg_pkg::CTRL_CLR]) begin
            for (int ch = 0; ch < 2; ch++) begin
              count_nxt[ch] = '0;
              ph_nxt[ch]    = '0;
            end
          end else if (ctrl_r[dspg_pkg::CTRL_EN]) begin
            // Advance each busy channel; wrap the phase and count one step
            for (int ch = 0; ch < 2; ch++) begin
              if (count_r[ch] != '0) begin
                if (ph_inc[ch] >= per_eff[ch]) begin
                  ph_nxt[ch]    = '0;
                  count_nxt[ch] = count_r[ch] - C'(1);
                end else begin
                  ph_nxt[ch] = ph_inc[ch][T-1:0];
                end
              end
            end
          end
        end
        dspg_pkg::OP_WRITE: begin
          case (in_ch.data.reg_addr)
            dspg_pkg::REG_CTRL: begin
              ctrl_nxt = in_ch.data.write_data[1:0];
              if (in_ch.data.write_data[dspg_pkg::CTRL_CLR]) begin
                for (int ch = 0; ch < 2; ch++) begin
                  count_nxt[ch] = '0;
                  ph_nxt[ch]    = '0;
                end
              end
            end
            dspg_pkg::REG_STEPS: begin
              count_nxt[0] = wd64[C-1:0];
              count_nxt[1] = wd64[2*C:C+1];
              dir_nxt      = {wd64[2*C+1], wd64[C]};
              ph_nxt[0]    = '0;
              ph_nxt[1]    = '0;
            end
            dspg_pkg::REG_PERIOD: begin
              per_nxt[0] = wd64[T-1:0];
              per_nxt[1] = wd64[2*T-1:T];
            end
            dspg_pkg::REG_WIDTH: begin
              wid_nxt[0] = wd64[T-1:0];
              wid_nxt[1] = wd64[2*T-1:T];
            end
            default: begin
            end
          endcase
        end
        dspg_pkg::OP_READ: begin
          case (in_ch.data.reg_addr)
            dspg_pkg::REG_CTRL:   rd64 = 64'(ctrl_r);
            dspg_pkg::REG_STEPS:  rd64 = 64'(count_r[0]) | (64'(dir_r[0]) << C) |
                                         (64'(count_r[1]) << (C+1)) |
                                         (64'(dir_r[1]) << (2*C+1));
            dspg_pkg::REG_PERIOD: rd64 = 64'(per_r[0]) | (64'(per_r[1]) << T);
            dspg_pkg::REG_WIDTH:  rd64 = 64'(wid_r[0]) | (64'(wid_r[1]) << T);
            default:              rd64 = 64'd0;
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  // Form the result word from the updated state
  always_comb begin
    result.read_data      = rd64[31:0];
    result.step_pin_left  = ctrl_nxt[dspg_pkg::CTRL_EN] && !ctrl_nxt[dspg_pkg::CTRL_CLR] &&
                            (count_nxt[0] != '0) && (ph_nxt[0] < wid_nxt[0]);
    result.step_pin_right = ctrl_nxt[dspg_pkg::CTRL_EN] && !ctrl_nxt[dspg_pkg::CTRL_CLR] &&
                            (count_nxt[1] != '0) && (ph_nxt[1] < wid_nxt[1]);
    result.dir_pin_left   = dir_nxt[0];
    result.dir_pin_right  = dir_nxt[1];
    result.driver_enable  = ctrl_nxt[dspg_pkg::CTRL_EN];
    result.all_done       = (count_nxt[0] == '0) && (count_nxt[1] == '0);
  end

  // Steer the result into the output register or the skid register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (out_take) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (accept) begin
        out_data_nxt = result;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r) begin
      if (accept) begin
        out_data_nxt  = result;
        out_valid_nxt = 1'b1;
      end
    end else if (accept) begin
      skid_data_nxt  = result;
      skid_valid_nxt = 1'b1;
    end
  end

  // Hold state and handshake registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r       <= '0;
      dir_r        <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      for (int ch = 0; ch < 2; ch++) begin
        count_r[ch] <= '0;
        ph_r[ch]    <= '0;
        per_r[ch]   <= T'(dspg_pkg::RESET_PERIOD);
        wid_r[ch]   <= T'(dspg_pkg::RESET_WIDTH);
      end
    end else begin
      ctrl_r       <= ctrl_nxt;
      dir_r        <= dir_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
      for (int ch = 0; ch < 2; ch++) begin
        count_r[ch] <= count_nxt[ch];
        ph_r[ch]    <= ph_nxt[ch];
        per_r[ch]   <= per_nxt[ch];
        wid_r[ch]   <= wid_nxt[ch];
      end
    end
  end

  // Drop payload into the data registers without reset
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  // A buffered word in the skid register always has one ahead of it
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held with empty output register");

  // A word accepted during an output stall lands in the skid register
  a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && out_valid_r && !out_ch.ready) |=> skid_valid_r)
    else $error("word accepted during stall was not buffered");

  // A tick with the clear bit set leaves both counts at zero
  a_clear_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_ch.data.opcode == dspg_pkg::OP_TICK) && ctrl_r[dspg_pkg::CTRL_CLR])
    |=> (count_r[0] == '0) && (count_r[1] == '0))
    else $error("clear tick left steps pending");

endmodule
